@@ hw/rtl/npbm_pkg.sv @@
`timescale 1ns / 1ps
package npbm_pkg;

  localparam int VALUE_BITS = 16;
  localparam int COUNT_BITS = 24;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_PIX  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [3:0] ERR_TYPE     = 4'd0;
  localparam logic [3:0] ERR_LZERO    = 4'd1;
  localparam logic [3:0] ERR_NONDIG   = 4'd2;
  localparam logic [3:0] ERR_ZSIZE    = 4'd3;
  localparam logic [3:0] ERR_FIELDS   = 4'd4;
  localparam logic [3:0] ERR_XMAXV    = 4'd5;
  localparam logic [3:0] ERR_MAXV     = 4'd6;
  localparam logic [3:0] ERR_GRID     = 4'd7;
  localparam logic [3:0] ERR_SAMPLE   = 4'd8;
  localparam logic [3:0] ERR_COUNT    = 4'd9;
  localparam logic [3:0] ERR_OVF      = 4'd10;
  localparam logic [3:0] ERR_HDR      = 4'd11;

  typedef struct packed {
    logic [1:0]            kind;
    logic [VALUE_BITS-1:0] red;
    logic [VALUE_BITS-1:0] green;
    logic [VALUE_BITS-1:0] blue;
    logic [COUNT_BITS-1:0] idx;
    logic [3:0]            err;
  } res_t;

  typedef struct packed {
    logic                  two;
    logic [2:0]            ty;
    logic [VALUE_BITS-1:0] w;
    logic [VALUE_BITS-1:0] h;
    logic [VALUE_BITS-1:0] m;
    res_t                  r0;
    res_t                  r1;
  } qent_t;

  typedef struct packed {
    logic             full;
    logic             empty;
  } qstat_t;

endpackage

@@ hw/rtl/npbm_front.sv @@
`timescale 1ns / 1ps
module npbm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  output logic              push,
  output npbm_pkg::qent_t   push_ent,
  input  npbm_pkg::qstat_t  qs
);

  localparam logic [2:0] PH_TYPE  = 3'd0;
  localparam logic [2:0] PH_RES   = 3'd1;
  localparam logic [2:0] PH_COMM  = 3'd2;
  localparam logic [2:0] PH_MAXV  = 3'd3;
  localparam logic [2:0] PH_GRIDB = 3'd4;
  localparam logic [2:0] PH_GRIDN = 3'd5;

  localparam int F_ACT = 0;
  localparam int F_LZ  = 1;
  localparam int F_NE  = 2;

  localparam int VB = npbm_pkg::VALUE_BITS;
  localparam int CB = npbm_pkg::COUNT_BITS;
  localparam int TB = 2 * VB;

  typedef struct packed {
    logic [2:0]    ph;
    logic [2:0]    ty;
    logic [VB-1:0] sw;
    logic [VB-1:0] sh;
    logic [VB-1:0] sm;
    logic [VB-1:0] tv;
    logic [2:0]    tf;
    logic [1:0]    lf;
    logic [1:0]    sc;
    logic [1:0]    lc;
    logic [1:0]    ci;
    logic [VB-1:0] hr;
    logic [VB-1:0] hg;
    logic [CB-1:0] pc;
    logic          nm;
    logic          hl;
    logic [1:0]    oc;
    npbm_pkg::res_t r0;
    npbm_pkg::res_t r1;
  } pst_t;

  pst_t          st_r, st_nxt, s;
  logic [TB-1:0] total_r;
  logic          settle_r;
  logic          acc;
  logic          cnt_bad;

  function automatic logic is_bm(pst_t x);
    return (x.ty == 3'd1) || (x.ty == 3'd4);
  endfunction

  function automatic logic is_col(pst_t x);
    return (x.ty == 3'd3) || (x.ty == 3'd6);
  endfunction

  function automatic pst_t put(pst_t x, logic [1:0] k, logic [VB-1:0] r, logic [VB-1:0] g,
                               logic [VB-1:0] b, logic [CB-1:0] i, logic [3:0] e);
    npbm_pkg::res_t o;
    o.kind = k; o.red = r; o.green = g; o.blue = b; o.idx = i; o.err = e;
    if (x.oc == 2'd0) x.r0 = o;
    else x.r1 = o;
    x.oc = x.oc + 2'd1;
    return x;
  endfunction

  function automatic pst_t fail(pst_t x, logic [3:0] e);
    x = put(x, npbm_pkg::KIND_ERR, '0, '0, '0, '0, e);
    x.hl = 1'b1;
    return x;
  endfunction

  function automatic pst_t pixel(pst_t x, logic [VB-1:0] r, logic [VB-1:0] g,
                                 logic [VB-1:0] b, logic [TB-1:0] tot);
    if (({{(TB-CB){1'b0}}, x.pc} >= tot) || (x.pc == {CB{1'b1}})) begin
      x = fail(x, npbm_pkg::ERR_COUNT);
    end else begin
      x = put(x, npbm_pkg::KIND_PIX, r, g, b, x.pc, '0);
      x.pc = x.pc + 1'b1;
    end
    return x;
  endfunction

  function automatic pst_t enter_grid(pst_t x);
    x.ph = is_bm(x) ? PH_GRIDB : PH_GRIDN;
    x = put(x, npbm_pkg::KIND_HDR, '0, '0, '0, '0, '0);
    return x;
  endfunction

  function automatic pst_t fin_tok(pst_t x, logic [TB-1:0] tot);
    logic [VB-1:0] v;
    v = x.tv;
    x.tf[F_ACT] = 1'b0;
    x.tf[F_LZ] = 1'b0;
    if (x.ph == PH_RES) begin
      if (x.lf == 2'd0) x.sw = v;
      else if (x.lf == 2'd1) x.sh = v;
      else x.sm = v;
      x.lf = x.lf + 2'd1;
    end else if (x.ph == PH_MAXV) begin
      x.lf = x.lf + 2'd1;
    end else if (x.ph == PH_GRIDN) begin
      if (v > x.sm) x = fail(x, npbm_pkg::ERR_SAMPLE);
      else if (!is_col(x)) x = pixel(x, v, v, v, tot);
      else if (x.ci == 2'd0) begin
        x.hr = v; x.ci = 2'd1;
      end else if (x.ci == 2'd1) begin
        x.hg = v; x.ci = 2'd2;
      end else begin
        x.ci = 2'd0;
        x = pixel(x, x.hr, x.hg, v, tot);
      end
    end
    return x;
  endfunction

  function automatic pst_t end_line(pst_t x, logic [TB-1:0] tot);
    if (x.tf[F_ACT]) x = fin_tok(x, tot);
    if (!x.hl) begin
      case (x.ph)
        PH_TYPE: begin
          if (x.lc == 2'd2) begin
            x.ty = x.tv[2:0];
            x.nm = !is_bm(x);
            x.ph = PH_RES;
          end else begin
            x = fail(x, npbm_pkg::ERR_TYPE);
          end
        end
        PH_COMM: x.ph = PH_RES;
        PH_RES: begin
          if (x.lf == 2'd2) begin
            if (x.sw == '0 || x.sh == '0) x = fail(x, npbm_pkg::ERR_ZSIZE);
            else if (x.nm) x.ph = PH_MAXV;
            else begin
              x.sm = {{(VB-1){1'b0}}, 1'b1};
              x = enter_grid(x);
            end
          end else if (x.lf == 2'd3) begin
            x.nm = 1'b0;
            x = enter_grid(x);
          end else begin
            x = fail(x, npbm_pkg::ERR_FIELDS);
          end
        end
        PH_MAXV: begin
          if (x.tv > VB'(255)) x = fail(x, npbm_pkg::ERR_MAXV);
          else begin
            x.sm = x.tv;
            x = enter_grid(x);
          end
        end
        default: ;
      endcase
      x.tf = '0; x.tv = '0; x.lf = '0; x.sc = '0; x.lc = '0;
    end
    return x;
  endfunction

  function automatic pst_t digit(pst_t x, logic [3:0] d);
    logic        ex;
    logic [VB+3:0] p;
    ex = 1'b0;
    p = '0;
    if (!x.tf[F_ACT]) begin
      if (x.ph == PH_RES && x.lf == 2'd3) x = fail(x, npbm_pkg::ERR_FIELDS);
      else if (x.ph == PH_MAXV && x.lf != 2'd0) x = fail(x, npbm_pkg::ERR_XMAXV);
      else begin
        ex = is_bm(x) && x.sc == 2'd0 && x.lf == 2'd0;
        x.tf[F_ACT] = 1'b1;
        if (d == 4'd0 && !ex) x.tf[F_LZ] = 1'b1;
        x.tv = {{(VB-4){1'b0}}, d};
      end
    end else if (x.tf[F_LZ]) begin
      x = fail(x, npbm_pkg::ERR_LZERO);
    end else begin
      p = ({4'b0, x.tv} << 3) + ({4'b0, x.tv} << 1) + {{VB{1'b0}}, d};
      x.tv = p[VB-1:0];
      if (p[VB+3:VB] != 4'd0) x = fail(x, npbm_pkg::ERR_OVF);
    end
    return x;
  endfunction

  function automatic pst_t step_byte(pst_t x, logic [7:0] b, logic [TB-1:0] tot);
    if (b == 8'd10) x = end_line(x, tot);
    else if (x.ph == PH_TYPE) begin
      x.tf[F_NE] = 1'b1;
      if (x.lc == 2'd0) begin
        if (b != 8'h50) x = fail(x, npbm_pkg::ERR_TYPE);
        else x.lc = x.lc + 2'd1;
      end else if (x.lc == 2'd1) begin
        if (b < 8'd49 || b > 8'd54) x = fail(x, npbm_pkg::ERR_TYPE);
        else begin
          x.tv = {{(VB-3){1'b0}}, b[2:0]};
          x.lc = x.lc + 2'd1;
        end
      end else begin
        x = fail(x, npbm_pkg::ERR_TYPE);
      end
    end else if (x.ph == PH_COMM) begin
      x.tf[F_NE] = 1'b1;
    end else if (x.ph == PH_GRIDB) begin
      x.tf[F_NE] = 1'b1;
      if (b == 8'd48 || b == 8'd49)
        x = pixel(x, {{(VB-1){1'b0}}, b[0]}, {{(VB-1){1'b0}}, b[0]},
                  {{(VB-1){1'b0}}, b[0]}, tot);
      else if (b != 8'd32) x = fail(x, npbm_pkg::ERR_GRID);
    end else if (x.ph == PH_RES && !x.tf[F_NE] && b == 8'd35) begin
      x.tf[F_NE] = 1'b1;
      x.ph = PH_COMM;
    end else if (b == 8'd32) begin
      x.tf[F_NE] = 1'b1;
      if (x.tf[F_ACT]) x = fin_tok(x, tot);
      if (x.sc != 2'd3) x.sc = x.sc + 2'd1;
    end else if (b >= 8'd48 && b <= 8'd57) begin
      x.tf[F_NE] = 1'b1;
      x = digit(x, b[3:0]);
    end else begin
      x = fail(x, npbm_pkg::ERR_NONDIG);
    end
    return x;
  endfunction

  function automatic pst_t rst_val();
    pst_t x;
    x = '0;
    x.ph = PH_TYPE;
    x.nm = 1'b1;
    return x;
  endfunction

  assign in_ready = !qs.full && !settle_r;
  assign acc      = in_valid && in_ready;

  always_comb begin
    s = st_r;
    s.oc = 2'd0;
    cnt_bad = 1'b0;
    if (in_end) begin
      if (!s.hl) begin
        if (s.tf[F_NE]) s = end_line(s, total_r);
        if (!s.hl) begin
          if (st_r.ph != PH_GRIDB && st_r.ph != PH_GRIDN)
            cnt_bad = (s.sw != '0) && (s.sh != '0);
          else
            cnt_bad = ({{(TB-CB){1'b0}}, s.pc} != total_r);
          if (s.ph != PH_GRIDB && s.ph != PH_GRIDN) s = fail(s, npbm_pkg::ERR_HDR);
          else if (s.ci != 2'd0 || cnt_bad)
            s = fail(s, npbm_pkg::ERR_COUNT);
          else s = put(s, npbm_pkg::KIND_DONE, '0, '0, '0, '0, '0);
        end
      end
    end else if (!s.hl) begin
      s = step_byte(s, in_byte, total_r);
    end
    push_ent.two = (s.oc == 2'd2);
    push_ent.ty  = s.ty;
    push_ent.w   = s.sw;
    push_ent.h   = s.sh;
    push_ent.m   = s.sm;
    push_ent.r0  = s.r0;
    push_ent.r1  = s.r1;
    push = acc && (s.oc != 2'd0);
    st_nxt = in_end ? rst_val() : s;
  end

  always_ff @(posedge clk) begin
    total_r <= TB'(st_r.sw) * TB'(st_r.sh);
    if (!rst_n) begin
      st_r     <= rst_val();
      settle_r <= 1'b0;
    end else begin
      settle_r <= acc && (s.oc != 2'd0) && (s.r0.kind == npbm_pkg::KIND_HDR);
      if (acc) st_r <= st_nxt;
    end
  end

endmodule

@@ hw/rtl/npbm_fifo.sv @@
`timescale 1ns / 1ps
module npbm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  npbm_pkg::qent_t   wr_ent,
  input  logic              pop,
  output npbm_pkg::qent_t   rd_ent,
  output npbm_pkg::qstat_t  qs
);

  npbm_pkg::qent_t              mem [npbm_pkg::QDEPTH];
  logic [npbm_pkg::QAW-1:0]     wp_r, rp_r;
  logic [npbm_pkg::QAW:0]       cnt_r;

  assign rd_ent   = mem[rp_r];
  assign qs.full  = (cnt_r == (npbm_pkg::QAW+1)'(npbm_pkg::QDEPTH));
  assign qs.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ hw/rtl/npbm_back.sv @@
`timescale 1ns / 1ps
module npbm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  npbm_pkg::qent_t   q_ent,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [127:0]      out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  npbm_pkg::qent_t ent_r;
  npbm_pkg::res_t  cur;
  logic            val_r, sel_r, lst, adv;

  assign cur = sel_r ? ent_r.r1 : ent_r.r0;
  assign lst = (sel_r == ent_r.two);
  assign adv = !val_r || (out_tready && lst);
  assign pop = adv && q_valid;

  assign out_tvalid = val_r;
  assign out_tuser  = cur.kind;
  assign out_tlast  = lst;
  assign out_tdata  = {1'b0, cur.err, cur.idx, cur.blue, cur.green, cur.red,
                       ent_r.m, ent_r.h, ent_r.w, ent_r.ty};

  always_ff @(posedge clk) begin
    if (pop) ent_r <= q_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
      sel_r <= 1'b0;
    end else if (adv) begin
      val_r <= q_valid;
      sel_r <= 1'b0;
    end else if (out_tready) begin
      sel_r <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/netpbm_text_image_parser.sv @@
`timescale 1ns / 1ps
// A byte's results are pushed into the queue as it is accepted, and the output
// stage registers each entry. Throughput: one byte per cycle while the queue has
// room; one cycle of no input after the header while the pixel total settles.
// Output: one result per cycle while out_tready is high; two results go in turn.
// Reset: synchronous active-low rst_n clears parser state and queue.
module netpbm_text_image_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // end_marker
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // image_type, width, height, maxval, red, green,
                                   // blue, pixel_index, error_code
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast   // last
);

  npbm_pkg::qent_t  wr_ent, rd_ent;
  npbm_pkg::qstat_t qs;
  logic             push, pop;

  npbm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_byte(in_tdata), .in_end(in_tlast),
    .push(push), .push_ent(wr_ent), .qs(qs)
  );

  npbm_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wr_ent(wr_ent),
    .pop(pop), .rd_ent(rd_ent), .qs(qs)
  );

  npbm_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(!qs.empty), .q_ent(rd_ent), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qs.full && !pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qs.empty))
    else $error("queue underflow");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == npbm_pkg::KIND_DONE) |-> out_tlast)
    else $error("done not last");

  a_hdr_noerr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == npbm_pkg::KIND_HDR) |-> out_tdata[126:123] == 4'd0)
    else $error("header carries error code");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import npbm_pkg::*;

  typedef enum int {PH_TYPE, PH_RES, PH_COMMENT, PH_MAXV, PH_GRIDB, PH_GRIDN} parse_ph_e;

  typedef struct packed {
    bit [1:0]  kind;
    bit [2:0]  ty;
    bit [15:0] w;
    bit [15:0] h;
    bit [15:0] m;
    bit [15:0] r;
    bit [15:0] g;
    bit [15:0] b;
    bit [23:0] idx;
    bit [3:0]  err;
    bit        last;
  } pnm_res_t;

  typedef struct {
    bit [7:0] byte_val;
    bit       eom;
    bit       chk;
    bit [1:0] kind;
    bit [3:0] err;
  } dir_row_t;

  localparam longint unsigned VAL_MAX = 64'd65535;
  localparam longint unsigned CNT_MAX = 64'd16777215;
  localparam bit [3:0] F_ACTIVE = 4'd1;
  localparam bit [3:0] F_LZ = 4'd2;
  localparam bit [3:0] F_NONEMPTY = 4'd4;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'd0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  netpbm_text_image_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #10 clk = ~clk;

  parse_ph_e       ph;
  bit [2:0]        s_type;
  longint unsigned s_w, s_h, s_max, tok, hred, hgreen, pcount;
  bit [3:0]        tflags;
  int unsigned     lfields, spc, lchars, comp;
  bit              need_max, halted;

  pnm_res_t pixel_q[$];
  pnm_res_t step_out[$];
  int errs = 0;
  int items = 0;
  int files = 0;
  int checked = 0;
  bit quiet = 1'b0;
  bit stall_req = 1'b0;
  bit [7:0] file_q[$];

  function automatic bit is_bitmap();
    return s_type == 3'd1 || s_type == 3'd4;
  endfunction

  function automatic bit is_color();
    return s_type == 3'd3 || s_type == 3'd6;
  endfunction

  function automatic void parser_clear();
    ph = PH_TYPE; s_type = 0; s_w = 0; s_h = 0; s_max = 0; tok = 0; tflags = 0;
    lfields = 0; spc = 0; lchars = 0; comp = 0; hred = 0; hgreen = 0; pcount = 0;
    need_max = 1; halted = 0;
  endfunction

  function automatic void emit(bit [1:0] kind, longint unsigned r, longint unsigned g,
                               longint unsigned b, longint unsigned idx, bit [3:0] err);
    pnm_res_t e;
    if (step_out.size() >= 2) return;
    e.kind = kind; e.ty = s_type; e.w = s_w[15:0]; e.h = s_h[15:0]; e.m = s_max[15:0];
    e.r = r[15:0]; e.g = g[15:0]; e.b = b[15:0]; e.idx = idx[23:0]; e.err = err; e.last = 0;
    step_out.insert(step_out.size(), e);
  endfunction

  function automatic void raise_err(bit [3:0] code);
    emit(KIND_ERR, 0, 0, 0, 0, code);
    halted = 1;
  endfunction

  function automatic void put_pixel(longint unsigned r, longint unsigned g, longint unsigned b);
    if (pcount >= s_w * s_h || pcount >= CNT_MAX) begin
      raise_err(ERR_COUNT);
      return;
    end
    emit(KIND_PIX, r, g, b, pcount, 0);
    pcount++;
  endfunction

  function automatic void enter_grid();
    ph = is_bitmap() ? PH_GRIDB : PH_GRIDN;
    emit(KIND_HDR, 0, 0, 0, 0, 0);
  endfunction

  function automatic void close_token();
    longint unsigned v;
    v = tok;
    tflags &= ~(F_ACTIVE | F_LZ);
    if (ph == PH_RES) begin
      if (lfields == 0) s_w = v;
      else if (lfields == 1) s_h = v;
      else s_max = v;
      lfields = (lfields + 1) & 3;
    end else if (ph == PH_MAXV) begin
      lfields = (lfields + 1) & 3;
    end else if (ph == PH_GRIDN) begin
      if (v > s_max) begin
        raise_err(ERR_SAMPLE);
        return;
      end
      if (!is_color()) begin
        put_pixel(v, v, v);
        return;
      end
      if (comp == 0) begin
        hred = v; comp = 1;
      end else if (comp == 1) begin
        hgreen = v; comp = 2;
      end else begin
        comp = 0; put_pixel(hred, hgreen, v);
      end
    end
  endfunction

  function automatic void close_line();
    if (tflags & F_ACTIVE) close_token();
    if (halted) return;
    case (ph)
      PH_TYPE: begin
        if (lchars == 2) begin
          s_type = tok[2:0];
          need_max = !is_bitmap();
          ph = PH_RES;
        end else begin
          raise_err(ERR_TYPE);
        end
      end
      PH_COMMENT: ph = PH_RES;
      PH_RES: begin
        if (lfields == 2) begin
          if (s_w == 0 || s_h == 0) raise_err(ERR_ZSIZE);
          else if (need_max) ph = PH_MAXV;
          else begin
            s_max = 1; enter_grid();
          end
        end else if (lfields == 3) begin
          need_max = 0; enter_grid();
        end else begin
          raise_err(ERR_FIELDS);
        end
      end
      PH_MAXV: begin
        if (tok > 255) raise_err(ERR_MAXV);
        else begin
          s_max = tok; enter_grid();
        end
      end
      default: ;
    endcase
    tflags = 0; tok = 0; lfields = 0; spc = 0; lchars = 0;
  endfunction

  function automatic void take_digit(int unsigned d);
    bit exempt;
    if (!(tflags & F_ACTIVE)) begin
      if (ph == PH_RES && lfields >= 3) begin
        raise_err(ERR_FIELDS);
        return;
      end
      if (ph == PH_MAXV && lfields >= 1) begin
        raise_err(ERR_XMAXV);
        return;
      end
      exempt = is_bitmap() && spc == 0 && lfields == 0;
      tflags |= F_ACTIVE;
      if (d == 0 && !exempt) tflags |= F_LZ;
      tok = d;
      return;
    end
    if (tflags & F_LZ) begin
      raise_err(ERR_LZERO);
      return;
    end
    tok = tok * 10 + d;
    if (tok > VAL_MAX) raise_err(ERR_OVF);
  endfunction

  function automatic void take_byte(bit [7:0] b);
    if (b == 8'd10) begin
      close_line();
      return;
    end
    if (ph == PH_TYPE) begin
      tflags |= F_NONEMPTY;
      if (lchars == 0) begin
        if (b != "P") begin
          raise_err(ERR_TYPE);
          return;
        end
      end else if (lchars == 1) begin
        if (b < 49 || b > 54) begin
          raise_err(ERR_TYPE);
          return;
        end
        tok = b - 48;
      end else begin
        raise_err(ERR_TYPE);
        return;
      end
      lchars++;
      return;
    end
    if (ph == PH_COMMENT) begin
      tflags |= F_NONEMPTY;
      return;
    end
    if (ph == PH_GRIDB) begin
      tflags |= F_NONEMPTY;
      if (b == "0" || b == "1") put_pixel(b - 48, b - 48, b - 48);
      else if (b != " ") raise_err(ERR_GRID);
      return;
    end
    if (ph == PH_RES && !(tflags & F_NONEMPTY) && b == "#") begin
      tflags |= F_NONEMPTY;
      ph = PH_COMMENT;
      return;
    end
    if (b == " ") begin
      tflags |= F_NONEMPTY;
      if (tflags & F_ACTIVE) close_token();
      if (spc < 3) spc++;
      return;
    end
    if (b >= 48 && b <= 57) begin
      tflags |= F_NONEMPTY;
      take_digit(b - 48);
      return;
    end
    raise_err(ERR_NONDIG);
  endfunction

  function automatic void predict_parse(bit [7:0] b, bit eom);
    step_out.delete();
    if (eom) begin
      if (!halted) begin
        if (tflags & F_NONEMPTY) take_byte(8'd10);
        if (!halted) begin
          if (ph != PH_GRIDB && ph != PH_GRIDN) raise_err(ERR_HDR);
          else if (comp != 0 || pcount != s_w * s_h) raise_err(ERR_COUNT);
          else emit(KIND_DONE, 0, 0, 0, 0, 0);
        end
      end
      parser_clear();
    end else if (!halted) begin
      take_byte(b);
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
    foreach (step_out[i]) pixel_q.insert(pixel_q.size(), step_out[i]);
  endfunction

  task automatic send_req(input bit [7:0] b, input bit eom);
    in_tdata <= b;
    in_tlast <= eom;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_parse(b, eom);
    items++;
    if (!quiet && $urandom_range(0, 15) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic void add_byte(bit [7:0] v);
    file_q.insert(file_q.size(), v);
  endfunction

  function automatic void push_num(longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void push_sep(bit eol);
    if (eol) add_byte(8'd10);
    else repeat ($urandom_range(1, 2)) add_byte(" ");
  endfunction

  function automatic void build_file();
    int t, w, h, m, n, mode, pos;
    file_q.delete();
    t = $urandom_range(1, 6);
    w = ($urandom_range(0, 24) == 0) ? 0 : $urandom_range(1, 4);
    h = $urandom_range(1, 4);
    add_byte("P");
    add_byte(8'(48 + t));
    add_byte(8'd10);
    if ($urandom_range(0, 3) == 0) begin
      add_byte("#");
      repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(11, 255)));
      add_byte(8'd10);
    end
    case ($urandom_range(0, 19))
      0: m = 0;
      1: m = 300;
      2: m = 65535;
      3: m = 255;
      default: m = $urandom_range(1, 255);
    endcase
    push_num(w); push_sep(0); push_num(h);
    if (t == 1 || t == 4) begin
      m = 1;
      add_byte(8'd10);
    end else if ($urandom_range(0, 1)) begin
      push_sep(0); push_num(m); add_byte(8'd10);
    end else begin
      add_byte(8'd10); push_num(m); add_byte(8'd10);
    end
    n = w * h * ((t == 3 || t == 6) ? 3 : 1);
    for (int i = 0; i < n; i++) begin
      if (t == 1 || t == 4) begin
        add_byte($urandom_range(0, 1) ? "1" : "0");
        if ($urandom_range(0, 3) == 0) add_byte(" ");
        if ((i % w) == w - 1) add_byte(8'd10);
      end else begin
        push_num($urandom_range(0, m));
        push_sep((i % 3) == 2);
      end
    end
    mode = $urandom_range(0, 11);
    pos = $urandom_range(0, file_q.size() - 1);
    case (mode)
      0: file_q[pos] = 8'($urandom_range(0, 255));
      1: repeat ($urandom_range(1, 3)) if (file_q.size() > 0) void'(file_q.pop_back());
      2: begin
        push_num($urandom_range(0, 1)); add_byte(8'd10);
      end
      3: begin
        file_q.insert(pos, " ");
        file_q.insert(pos, "9"); file_q.insert(pos, "9"); file_q.insert(pos, "9");
        file_q.insert(pos, "9"); file_q.insert(pos, "9");
      end
      4: file_q.insert(pos, "0");
      5: if (file_q[file_q.size() - 1] == 8'd10) void'(file_q.pop_back());
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, pnm_res_t e, pnm_res_t a);
    errs++;
    if (errs <= 10) begin
      $display("mismatch %s: exp kind=%0d ty=%0d w=%0d h=%0d m=%0d rgb=%0d/%0d/%0d idx=%0d",
        what, e.kind, e.ty, e.w, e.h, e.m, e.r, e.g, e.b, e.idx);
      $display("  exp err=%0d last=%0d | act kind=%0d ty=%0d w=%0d h=%0d m=%0d",
        e.err, e.last, a.kind, a.ty, a.w, a.h, a.m);
      $display("  act rgb=%0d/%0d/%0d idx=%0d err=%0d last=%0d",
        a.r, a.g, a.b, a.idx, a.err, a.last);
    end
  endfunction

  always @(posedge clk) begin
    pnm_res_t a, e;
    if (rst_n && out_tvalid && out_tready) begin
      a.kind = out_tuser; a.ty = out_tdata[2:0]; a.w = out_tdata[18:3];
      a.h = out_tdata[34:19]; a.m = out_tdata[50:35]; a.r = out_tdata[66:51];
      a.g = out_tdata[82:67]; a.b = out_tdata[98:83]; a.idx = out_tdata[122:99];
      a.err = out_tdata[126:123]; a.last = out_tlast;
      checked++;
      if (pixel_q.size() == 0) begin
        e = '0;
        note_mismatch("unexpected", e, a);
      end else begin
        e = pixel_q.pop_front();
        if (a != e) note_mismatch("field", e, a);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        stall_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    dir_row_t dir_tab[29];
    dir_tab = '{
      '{8'd0, 1, 1, KIND_ERR, ERR_HDR},
      '{"P", 0, 0, KIND_HDR, 0}, '{"7", 0, 1, KIND_ERR, ERR_TYPE}, '{8'd0, 1, 0, KIND_HDR, 0},
      '{"P", 0, 0, KIND_HDR, 0}, '{"1", 0, 0, KIND_HDR, 0}, '{8'd10, 0, 0, KIND_HDR, 0},
      '{"#", 0, 0, KIND_HDR, 0}, '{8'hFF, 0, 0, KIND_HDR, 0}, '{8'd10, 0, 0, KIND_HDR, 0},
      '{"2", 0, 0, KIND_HDR, 0}, '{" ", 0, 0, KIND_HDR, 0}, '{" ", 0, 0, KIND_HDR, 0},
      '{"1", 0, 0, KIND_HDR, 0}, '{8'd10, 0, 1, KIND_HDR, 0}, '{"1", 0, 0, KIND_HDR, 0},
      '{"0", 0, 0, KIND_HDR, 0}, '{8'd0, 1, 1, KIND_DONE, 0},
      '{"P", 0, 0, KIND_HDR, 0}, '{"3", 0, 0, KIND_HDR, 0}, '{8'd10, 0, 0, KIND_HDR, 0},
      '{"1", 0, 0, KIND_HDR, 0}, '{" ", 0, 0, KIND_HDR, 0}, '{"1", 0, 0, KIND_HDR, 0},
      '{" ", 0, 0, KIND_HDR, 0}, '{"0", 0, 0, KIND_HDR, 0}, '{"5", 0, 1, KIND_ERR, ERR_LZERO},
      '{8'd0, 1, 0, KIND_HDR, 0}, '{8'h55, 1, 1, KIND_ERR, ERR_HDR}
    };
    parser_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].byte_val, dir_tab[i].eom);
      if (dir_tab[i].chk && (step_out.size() == 0 || step_out[0].kind != dir_tab[i].kind ||
          step_out[0].err != dir_tab[i].err)) begin
        errs++;
        if (errs <= 10)
          $display("mismatch directed row %0d: exp kind=%0d err=%0d", i,
                   dir_tab[i].kind, dir_tab[i].err);
      end
    end
    while (items < 1450) begin
      build_file();
      files++;
      if (files == 5) stall_req = 1'b1;
      if (files == 12) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pixel_q.size() != 0);
      end
      quiet = items > 1250;
      foreach (file_q[i]) send_req(file_q[i], 1'b0);
      send_req($urandom_range(0, 255), 1'b1);
    end
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pixel_q.size() != 0);
    repeat (20) @(posedge clk);
    $display("Parsed %0d files in %0d bytes and markers; %0d results compared.",
             files, items, checked);
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", errs);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
